// ===== rtl/omd_pkg.sv =====
package omd_pkg;

    localparam logic [1:0] SLOT_NONE  = 2'd0;
    localparam logic [1:0] SLOT_LEFT  = 2'd1;
    localparam logic [1:0] SLOT_RIGHT = 2'd2;

    localparam logic [1:0] MSLOT_NONE   = 2'd0;
    localparam logic [1:0] MSLOT_BEFORE = 2'd1;
    localparam logic [1:0] MSLOT_AFTER  = 2'd2;

    localparam logic [4:0] LOC_UNCHANGED = 5'd0;
    localparam logic [4:0] LOC_MEM_DATA  = 5'd1;
    localparam logic [4:0] LOC_SFI1      = 5'd2;
    localparam logic [4:0] LOC_SFI2      = 5'd3;
    localparam logic [4:0] LOC_RM1       = 5'd4;
    localparam logic [4:0] LOC_IMM1      = 5'd5;
    localparam logic [4:0] LOC_LOW_REG   = 5'd6;
    localparam logic [4:0] LOC_WIDE_REG  = 5'd14;

    localparam logic [1:0] SEXT_UNCHANGED = 2'd0;
    localparam logic [1:0] SEXT_CLEAR     = 2'd1;
    localparam logic [1:0] SEXT_SET       = 2'd2;

    localparam logic [3:0] ENT_NONE     = 4'd0;
    localparam logic [3:0] ENT_REG_AUTO = 4'd1;
    localparam logic [3:0] ENT_REG_BITS = 4'd2;
    localparam logic [3:0] ENT_IMM_BITS = 4'd3;
    localparam logic [3:0] ENT_PGC_IMM  = 4'd4;
    localparam logic [3:0] ENT_IMM_RM   = 4'd5;
    localparam logic [3:0] ENT_IMM      = 4'd6;
    localparam logic [3:0] ENT_REG_POST = 4'd7;
    localparam logic [3:0] ENT_REG      = 4'd8;
    localparam logic [3:0] ENT_REG_IMM  = 4'd9;

    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_24 = 2'd2;

    localparam logic [4:0] RSEL_WIDE   = 5'h08;
    localparam logic [4:0] RSEL_SECOND = 5'h10;

    localparam logic [1:0] COUNT_MAX = 2'd3;

    typedef struct packed {
        logic       start_instruction;
        logic [5:0] rm;
        logic       is_dest;
        logic       left_source;
        logic [1:0] size;
        logic [3:0] length_so_far;
    } t_in_item;

    typedef struct packed {
        logic [1:0] operand_number;
        logic [3:0] second_offset;
        logic [1:0] src_slot;
        logic [1:0] src_size;
        logic [4:0] src_location;
        logic [1:0] src_sign_extend;
        logic [1:0] mucode_slot;
        logic [3:0] mucode_entry;
        logic [4:0] reg_sel;
        logic       mucode_is_write;
        logic       core_writeback;
        logic [1:0] extra_words;
    } t_out_item;

endpackage

// ===== rtl/operand_mode_decoder_top.sv =====
// The result is valid at the output register in the cycle after its input transfer.
// Throughput: one item per cycle; the output register takes a new result whenever
// it is empty or its current result transfers in the same cycle.
// Reset: synchronous active-low i_rst_n clears the output valid and the operand
// counter; the first operand after reset without a start is operand 1.
module operand_mode_decoder_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  omd_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output omd_pkg::t_out_item o_out_data
);

    logic               r_out_valid;
    omd_pkg::t_out_item r_out_data;
    omd_pkg::t_out_item n_out_data;
    logic [1:0]         r_count;
    logic [1:0]         n_count;
    logic               in_xfer;

    logic [5:0] rm;
    logic [2:0] rreg;
    logic       slot_on;
    logic       fetch;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign rm   = i_in_data.rm;
    assign rreg = rm[4:2];

    always_comb begin
        if (i_in_data.start_instruction) begin
            n_count = 2'd1;
        end else if (r_count < omd_pkg::COUNT_MAX) begin
            n_count = r_count + 2'd1;
        end else begin
            n_count = omd_pkg::COUNT_MAX;
        end
    end

    assign fetch = ((rm & 6'h21) == 6'h20) || ((rm & 6'h23) == 6'h01)
                || ((rm & 6'h23) == 6'h02)
                || (((rm & 6'h23) == 6'h21) && ((rm & 6'h1c) > 6'h04));

    always_comb begin
        n_out_data = '0;
        n_out_data.operand_number = n_count;
        n_out_data.second_offset  = (n_count == 2'd2) ? i_in_data.length_so_far : 4'd0;

        if (i_in_data.left_source) begin
            n_out_data.src_slot = omd_pkg::SLOT_LEFT;
        end else if (!i_in_data.is_dest) begin
            n_out_data.src_slot = omd_pkg::SLOT_RIGHT;
        end else begin
            n_out_data.src_slot = omd_pkg::SLOT_NONE;
        end
        slot_on = (n_out_data.src_slot != omd_pkg::SLOT_NONE);
        if (slot_on) begin
            n_out_data.src_size = i_in_data.size;
        end

        if (fetch) begin
            if (slot_on) begin
                n_out_data.src_location = omd_pkg::LOC_MEM_DATA;
            end
            if (i_in_data.is_dest && i_in_data.left_source) begin
                n_out_data.mucode_slot    = omd_pkg::MSLOT_BEFORE;
                n_out_data.core_writeback = 1'b1;
            end else if (i_in_data.is_dest) begin
                n_out_data.mucode_slot = omd_pkg::MSLOT_AFTER;
            end else begin
                n_out_data.mucode_slot = omd_pkg::MSLOT_BEFORE;
            end
            n_out_data.mucode_is_write = i_in_data.is_dest;
        end

        if (slot_on && (rm[1:0] == 2'b11)) begin
            n_out_data.src_sign_extend = omd_pkg::SEXT_CLEAR;
            n_out_data.src_location    = (n_count != 2'd1) ? omd_pkg::LOC_SFI2
                                                           : omd_pkg::LOC_SFI1;
        end else if ((rm & 6'h23) == 6'h22) begin
            n_out_data.mucode_entry = omd_pkg::ENT_REG_AUTO;
            n_out_data.reg_sel      = {2'b00, rreg};
        end else if ((rm & 6'h3b) == 6'h39) begin
            if (!rm[2]) begin
                n_out_data.extra_words  = 2'd1;
                n_out_data.mucode_entry = omd_pkg::ENT_REG_BITS;
            end else begin
                n_out_data.extra_words  = 2'd2;
                n_out_data.mucode_entry = omd_pkg::ENT_IMM_BITS;
            end
        end else if ((rm & 6'h3b) == 6'h31) begin
            n_out_data.mucode_entry = omd_pkg::ENT_PGC_IMM;
            if (!rm[2]) begin
                n_out_data.extra_words = 2'd1;
                n_out_data.reg_sel     = omd_pkg::RSEL_WIDE;
            end else begin
                n_out_data.extra_words = 2'd2;
            end
        end else if ((rm & 6'h3b) == 6'h29) begin
            n_out_data.extra_words  = rm[2] ? 2'd2 : 2'd1;
            n_out_data.mucode_entry = (n_count != 2'd1) ? omd_pkg::ENT_IMM_RM
                                                        : omd_pkg::ENT_IMM;
            n_out_data.reg_sel      = rm[2] ? 5'd0 : omd_pkg::RSEL_WIDE;
        end else if (slot_on && ((rm & 6'h3b) == 6'h21)) begin
            n_out_data.extra_words     = rm[2] ? 2'd2 : 2'd1;
            n_out_data.src_size        = rm[2] ? omd_pkg::SIZE_24 : omd_pkg::SIZE_16;
            n_out_data.src_location    = (n_count != 2'd1) ? omd_pkg::LOC_RM1
                                                           : omd_pkg::LOC_IMM1;
            n_out_data.src_sign_extend = rm[2] ? omd_pkg::SEXT_CLEAR
                                               : omd_pkg::SEXT_SET;
        end else if ((rm & 6'h23) == 6'h20) begin
            n_out_data.mucode_entry = omd_pkg::ENT_REG_POST;
            n_out_data.reg_sel      = {2'b00, rreg};
        end else if ((rm & 6'h23) == 6'h02) begin
            n_out_data.mucode_entry = omd_pkg::ENT_REG;
            n_out_data.reg_sel      = {2'b00, rreg};
        end else if ((rm & 6'h23) == 6'h01) begin
            n_out_data.mucode_entry = omd_pkg::ENT_REG_IMM;
            n_out_data.reg_sel      = {2'b00, rreg};
        end else if (slot_on && ((rm & 6'h23) == 6'h00)) begin
            n_out_data.src_location = (i_in_data.size == omd_pkg::SIZE_8)
                ? omd_pkg::LOC_LOW_REG + {2'b00, rreg}
                : omd_pkg::LOC_WIDE_REG + {2'b00, rreg};
        end

        if ((n_count == 2'd2) && (n_out_data.mucode_entry != omd_pkg::ENT_NONE)) begin
            n_out_data.reg_sel = n_out_data.reg_sel | omd_pkg::RSEL_SECOND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= 2'd0;
        end else begin
            if (in_xfer) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_data <= n_out_data;
        end
    end

    a_start_is_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.start_instruction) |=> (o_out_data.operand_number == 2'd1))
        else $error("start did not restart the operand count");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.operand_number != 2'd0))
        else $error("operand number zero on a valid result");

    a_rsel_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.mucode_entry == omd_pkg::ENT_NONE))
            |-> (o_out_data.reg_sel == 5'd0))
        else $error("register select without a microcode entry");

    a_offset_second_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.operand_number != 2'd2))
            |-> (o_out_data.second_offset == 4'd0))
        else $error("second operand offset outside the second operand");

endmodule
